// ===== rtl/lawf_pkg.sv =====
// Shared constants for the line angle window filter.
// CORDIC arctangent table, angle format and register index codes; no dependencies.
package lawf_pkg;

  localparam int CORDIC_STEPS   = 24;
  localparam int INT_ANGLE_BITS = 30;  // z accumulator angle unit: pi / 2^30
  localparam int Z_BITS         = 32;  // signed accumulator width, holds sum of table
  localparam int SCALE_BITS     = 32;  // fraction bits added to x and y before rotation

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_ANGLE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_TOLERANCE = 2'd1;

  // atan(2^-i) in units of pi / 2^30, rounded to nearest
  localparam logic [Z_BITS-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'd268435456, 32'd158466703, 32'd83729454, 32'd42502378,
    32'd21333665,  32'd10677233,  32'd5339919,  32'd2670122,
    32'd1335082,   32'd667543,    32'd333772,   32'd166886,
    32'd83443,     32'd41722,     32'd20861,    32'd10430,
    32'd5215,      32'd2608,      32'd1304,     32'd652,
    32'd326,       32'd163,       32'd81,       32'd41
  };

endpackage

// ===== rtl/lawf_cordic_stage.sv =====
// One registered micro-rotation of the vectoring CORDIC.
// Uses lawf_pkg for the arctangent table and accumulator width.
module lawf_cordic_stage #(
  parameter int W    = 48,
  parameter int STEP = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [W-1:0]               x_i,
  input  logic signed [W-1:0]               y_i,
  input  logic signed [lawf_pkg::Z_BITS-1:0] z_i,
  output logic                              valid_o,
  output logic signed [W-1:0]               x_o,
  output logic signed [W-1:0]               y_o,
  output logic signed [lawf_pkg::Z_BITS-1:0] z_o
);
  import lawf_pkg::*;

  localparam logic signed [Z_BITS-1:0] ATAN_STEP = ATAN_TABLE[STEP];

  logic                     valid_q;
  logic signed [W-1:0]      x_d, x_q, y_d, y_q;
  logic signed [Z_BITS-1:0] z_d, z_q;
  logic signed [W-1:0]      x_sh, y_sh;

  // arithmetic shift floors toward minus infinity
  assign x_sh = x_i >>> STEP;
  assign y_sh = y_i >>> STEP;

  always_comb begin
    if (!y_i[W-1]) begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + ATAN_STEP;
    end else begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== rtl/line_angle_window_filter.sv =====
// Line angle window filter top level: segment direction via pipelined CORDIC, window test.
// Depends on lawf_pkg and lawf_cordic_stage.
//
// Usage:
//   Input channel: one segment (two endpoints plus last_segment_i) is taken at every
//   rising edge with start high and busy low. busy never rises, so a segment may be
//   presented on every cycle.
//   Result channel: done_o is high for exactly one cycle with the segment, its folded
//   angle (units of pi / 2^ANGLE_BITS), the keep flag and last_out_o. The receiver
//   cannot stall; results are never held.
//   Pipeline: 1 prep stage, 24 CORDIC stages, 1 rounding stage, 1 window/output
//   stage. Throughput is one segment per cycle, set by the fully unrolled CORDIC
//   pipeline.
//   Config: cfg_we_i writes cfg_wdata_i to the register at cfg_idx_i (0 target angle,
//   1 tolerance); other indices are dropped. Write only while the pipe is empty.
//   Reset: valid bits and config registers clear (target 0, tolerance 0); in-flight
//   segments are discarded.
module line_angle_window_filter #(
  parameter int COORD_BITS = 12,
  parameter int ANGLE_BITS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [COORD_BITS-1:0]             start_x_i,
  input  logic [COORD_BITS-1:0]             start_y_i,
  input  logic [COORD_BITS-1:0]             end_x_i,
  input  logic [COORD_BITS-1:0]             end_y_i,
  input  logic                              last_segment_i,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [lawf_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ANGLE_BITS-1:0]             cfg_wdata_i,
  // result strobe
  output logic                              done_o,
  output logic [COORD_BITS-1:0]             out_start_x_o,
  output logic [COORD_BITS-1:0]             out_start_y_o,
  output logic [COORD_BITS-1:0]             out_end_x_o,
  output logic [COORD_BITS-1:0]             out_end_y_o,
  output logic [ANGLE_BITS-1:0]             segment_angle_o,
  output logic                              keep_o,
  output logic                              last_out_o
);
  import lawf_pkg::*;

  // x/y datapath: sign, CORDIC gain headroom, integer part, 32 fraction bits
  localparam int W        = COORD_BITS + 36;
  localparam int DW       = COORD_BITS + 1;
  localparam int SIDE_N   = CORDIC_STEPS + 2;   // prep, cordic, rounding stages
  localparam int LATENCY  = CORDIC_STEPS + 3;
  localparam logic [INT_ANGLE_BITS-1:0] ROUND_HALF =
    INT_ANGLE_BITS'(1) << (INT_ANGLE_BITS - 1 - ANGLE_BITS);

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic                  last;
    logic                  zero_len;
  } side_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] target;
    logic [ANGLE_BITS-1:0] pos_edge;
    logic                  pos_wrap;
    logic [ANGLE_BITS-1:0] neg_edge;
    logic                  neg_wrap;
  } win_t;

  // ---------------------------------------------------------------------------
  // Config registers and precomputed window edges
  // ---------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] target_q, tol_q;
  win_t                  win_d, win_q;
  logic [ANGLE_BITS:0]   pos_sum, neg_diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      tol_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_ANGLE:    target_q <= cfg_wdata_i;
        REG_ANGLE_TOLERANCE: tol_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Edges past pi or below zero wrap by one half turn, i.e. drop the carry/borrow bit.
  assign pos_sum  = {1'b0, target_q} + {1'b0, tol_q};
  assign neg_diff = {1'b0, target_q} - {1'b0, tol_q};

  always_comb begin
    win_d.target   = target_q;
    win_d.pos_edge = pos_sum[ANGLE_BITS-1:0];
    win_d.pos_wrap = pos_sum[ANGLE_BITS];
    win_d.neg_edge = neg_diff[ANGLE_BITS-1:0];
    win_d.neg_wrap = neg_diff[ANGLE_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Prep stage: differences, fold into right half plane, scale
  // ---------------------------------------------------------------------------
  logic                 in_fire;
  logic signed [DW-1:0] dx, dy, fx, fy;
  logic                 flip;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // CORDIC x input is the y difference, y input the x difference
  assign dx = $signed({1'b0, start_y_i}) - $signed({1'b0, end_y_i});
  assign dy = $signed({1'b0, start_x_i}) - $signed({1'b0, end_x_i});
  assign flip = dx[DW-1] || ((dx == '0) && dy[DW-1]);
  assign fx   = flip ? -dx : dx;
  assign fy   = flip ? -dy : dy;

  logic                     valid_w [CORDIC_STEPS+1];
  logic signed [W-1:0]      x_w     [CORDIC_STEPS+1];
  logic signed [W-1:0]      y_w     [CORDIC_STEPS+1];
  logic signed [Z_BITS-1:0] z_w     [CORDIC_STEPS+1];

  logic                valid0_q;
  logic signed [W-1:0] x0_q, y0_q;
  side_t               side_q [SIDE_N];
  side_t               side_in;

  always_comb begin
    side_in.sx       = start_x_i;
    side_in.sy       = start_y_i;
    side_in.ex       = end_x_i;
    side_in.ey       = end_y_i;
    side_in.last     = last_segment_i;
    side_in.zero_len = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else begin
      valid0_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q      <= $signed({{(W-DW){fx[DW-1]}}, fx}) <<< SCALE_BITS;
    y0_q      <= $signed({{(W-DW){fy[DW-1]}}, fy}) <<< SCALE_BITS;
    side_q[0] <= side_in;
  end

  assign valid_w[0] = valid0_q;
  assign x_w[0]     = x0_q;
  assign y_w[0]     = y0_q;
  assign z_w[0]     = '0;

  // ---------------------------------------------------------------------------
  // CORDIC pipeline, one micro-rotation per stage; side data rides alongside
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    lawf_cordic_stage #(
      .W    (W),
      .STEP (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[i]),
      .x_i     (x_w[i]),
      .y_i     (y_w[i]),
      .z_i     (z_w[i]),
      .valid_o (valid_w[i+1]),
      .x_o     (x_w[i+1]),
      .y_o     (y_w[i+1]),
      .z_o     (z_w[i+1])
    );

    always_ff @(posedge clk_i) begin
      side_q[i+1] <= side_q[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Rounding stage: angle mod half turn, round half up to ANGLE_BITS
  // ---------------------------------------------------------------------------
  logic                      valid_r_q;
  logic [ANGLE_BITS-1:0]     angle_q;
  logic [INT_ANGLE_BITS-1:0] z_round;

  assign z_round = z_w[CORDIC_STEPS][INT_ANGLE_BITS-1:0] + ROUND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_r_q <= 1'b0;
    end else begin
      valid_r_q <= valid_w[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= side_q[CORDIC_STEPS].zero_len ? '0
             : z_round[INT_ANGLE_BITS-1 -: ANGLE_BITS];
    side_q[CORDIC_STEPS+1] <= side_q[CORDIC_STEPS];
  end

  // ---------------------------------------------------------------------------
  // Window test and output register
  // ---------------------------------------------------------------------------
  logic  pos_ok, neg_ok;
  logic  le_pos, ge_tgt, ge_neg, le_tgt;
  side_t side_r;

  assign side_r = side_q[CORDIC_STEPS+1];
  assign le_pos = angle_q <= win_q.pos_edge;
  assign ge_tgt = angle_q >= win_q.target;
  assign ge_neg = angle_q >= win_q.neg_edge;
  assign le_tgt = angle_q <= win_q.target;
  assign pos_ok = win_q.pos_wrap ? (le_pos || ge_tgt) : (le_pos && ge_tgt);
  assign neg_ok = win_q.neg_wrap ? (ge_neg || le_tgt) : (ge_neg && le_tgt);

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_x_o   <= side_r.sx;
    out_start_y_o   <= side_r.sy;
    out_end_x_o     <= side_r.ex;
    out_end_y_o     <= side_r.ey;
    last_out_o      <= side_r.last;
    segment_angle_o <= angle_q;
    keep_o          <= pos_ok || neg_ok;
  end

  assign done_o = done_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a result strobe always traces back to a transaction a fixed latency earlier
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result strobe without matching transaction");

  // side data stays aligned with its valid bit through the whole pipe
  a_side_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_start_x_o == $past(start_x_i, LATENCY)) &&
               (out_end_y_o == $past(end_y_i, LATENCY)) &&
               (last_out_o == $past(last_segment_i, LATENCY)))
    else $error("segment data misaligned with result strobe");

  // after full rotation the vector sits on the positive x axis: no overflow, right turns
  a_cordic_converged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[CORDIC_STEPS] |->
      (x_w[CORDIC_STEPS] >= y_w[CORDIC_STEPS]) &&
      (x_w[CORDIC_STEPS] >= -y_w[CORDIC_STEPS]))
    else $error("CORDIC output not converged onto x axis");

endmodule

// ===== sim/lawf_checker.sv =====
// Scoreboard for the line angle window filter: predicts each segment's folded angle and keep flag.
// Depends on lawf_pkg for register index codes; watches the ports of the block only.
module lawf_checker #(
  parameter int COORD_BITS = 12,
  parameter int ANGLE_BITS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic [COORD_BITS-1:0]             start_x_i,
  input  logic [COORD_BITS-1:0]             start_y_i,
  input  logic [COORD_BITS-1:0]             end_x_i,
  input  logic [COORD_BITS-1:0]             end_y_i,
  input  logic                              last_segment_i,
  input  logic                              cfg_we_i,
  input  logic [lawf_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ANGLE_BITS-1:0]             cfg_wdata_i,
  input  logic                              done_o,
  input  logic [COORD_BITS-1:0]             out_start_x_o,
  input  logic [COORD_BITS-1:0]             out_start_y_o,
  input  logic [COORD_BITS-1:0]             out_end_x_o,
  input  logic [COORD_BITS-1:0]             out_end_y_o,
  input  logic [ANGLE_BITS-1:0]             segment_angle_o,
  input  logic                              keep_o,
  input  logic                              last_out_o,
  output int                                fail_count,
  output int                                pending,
  output int                                result_count,
  output int                                kept_count
);
  import lawf_pkg::*;

  localparam int ROT_STEPS = 24;

  // atan(2^-i), units of pi / 2^30
  localparam longint ATAN_PI30 [ROT_STEPS] = '{
    268435456, 158466703, 83729454, 42502378, 21333665, 10677233,
    5339919, 2670122, 1335082, 667543, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608,
    1304, 652, 326, 163, 81, 41
  };

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [ANGLE_BITS-1:0] angle;
    logic                  keep;
    logic                  last;
  } segment_verdict_t;

  segment_verdict_t      verdict_q[$];
  logic [ANGLE_BITS-1:0] target_angle;
  logic [ANGLE_BITS-1:0] angle_tolerance;

  // Vectoring CORDIC on (cos_arg, sin_arg), folded into a half turn.
  function automatic logic [ANGLE_BITS-1:0] segment_direction(longint cos_arg, longint sin_arg);
    longint xc, yc, zacc, xs, ys;
    int     rounded;
    if (cos_arg == 0 && sin_arg == 0) return '0;
    xc = cos_arg;
    yc = sin_arg;
    zacc = 0;
    // half-turn fold: flip into the right half plane
    if (xc < 0 || (xc == 0 && yc < 0)) begin
      xc = -xc;
      yc = -yc;
    end
    xc = xc <<< 32;
    yc = yc <<< 32;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = xc >>> i;
      ys = yc >>> i;
      if (yc >= 0) begin
        xc = xc + ys;
        yc = yc - xs;
        zacc = zacc + ATAN_PI30[i];
      end else begin
        xc = xc - ys;
        yc = yc + xs;
        zacc = zacc - ATAN_PI30[i];
      end
    end
    rounded = (int'(zacc[29:0]) + (1 << (29 - ANGLE_BITS))) >>> (30 - ANGLE_BITS);
    return rounded[ANGLE_BITS-1:0];
  endfunction

  // Window test around the target, each edge wrapping across a half turn.
  function automatic logic in_window(int ang, int tgt, int tol);
    int  half, hi_edge, lo_edge;
    logic hi_ok, lo_ok;
    half = 1 << ANGLE_BITS;
    hi_edge = tgt + tol;
    lo_edge = tgt - tol;
    if (hi_edge >= half) hi_ok = (ang <= hi_edge - half) || (ang >= tgt);
    else                 hi_ok = (ang <= hi_edge) && (ang >= tgt);
    if (lo_edge < 0) lo_ok = (ang >= lo_edge + half) || (ang <= tgt);
    else             lo_ok = (ang >= lo_edge) && (ang <= tgt);
    return hi_ok || lo_ok;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
    kept_count = 0;
    target_angle = '0;
    angle_tolerance = '0;
  end

  always @(posedge clk_i) begin
    segment_verdict_t want, got;
    if (!rst_ni) begin
      verdict_q.delete();
      target_angle = '0;
      angle_tolerance = '0;
    end else begin
      if (done_o) begin
        got = '{out_start_x_o, out_start_y_o, out_end_x_o, out_end_y_o,
                segment_angle_o, keep_o, last_out_o};
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
        end else begin
          want = verdict_q.pop_front();
          result_count++;
          if (want.keep) kept_count++;
          check_field("out_start_x", want.sx, got.sx);
          check_field("out_start_y", want.sy, got.sy);
          check_field("out_end_x", want.ex, got.ex);
          check_field("out_end_y", want.ey, got.ey);
          check_field("segment_angle", want.angle, got.angle);
          check_field("keep", want.keep, got.keep);
          check_field("last_out", want.last, got.last);
        end
      end
      if (start && !busy) begin
        want.sx = start_x_i;
        want.sy = start_y_i;
        want.ex = end_x_i;
        want.ey = end_y_i;
        want.last = last_segment_i;
        // atan2 with the x difference as sine argument, y difference as cosine
        want.angle = segment_direction(longint'(start_y_i) - longint'(end_y_i),
                                       longint'(start_x_i) - longint'(end_x_i));
        want.keep = in_window(int'(want.angle), int'(target_angle), int'(angle_tolerance));
        verdict_q = {verdict_q, want};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET_ANGLE:    target_angle = cfg_wdata_i;
          REG_ANGLE_TOLERANCE: angle_tolerance = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the line angle window filter testbench: clock, reset, segment and register stimulus.
// Depends on lawf_pkg, line_angle_window_filter and lawf_checker (prediction and compare).
module testbench;
  import lawf_pkg::*;

  localparam int COORD_BITS  = 12;
  localparam int ANGLE_BITS  = 15;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int ANGLE_MAX   = (1 << ANGLE_BITS) - 1;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 178;
  localparam int SETTLE      = 40;     // settle time with margin past the pipe depth
  localparam int CYCLE_LIMIT = 200000; // run limit for the watchdog below

  // index past the register list; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [COORD_BITS-1:0]   start_x_i = '0;
  logic [COORD_BITS-1:0]   start_y_i = '0;
  logic [COORD_BITS-1:0]   end_x_i = '0;
  logic [COORD_BITS-1:0]   end_y_i = '0;
  logic                    last_segment_i = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = REG_TARGET_ANGLE;
  logic [ANGLE_BITS-1:0]   cfg_wdata_i = '0;
  logic                    done_o;
  logic [COORD_BITS-1:0]   out_start_x_o, out_start_y_o, out_end_x_o, out_end_y_o;
  logic [ANGLE_BITS-1:0]   segment_angle_o;
  logic                    keep_o;
  logic                    last_out_o;

  int fail_count, pending, result_count, kept_count;
  int cycles = 0;
  int segments_sent = 0;
  int list_left = 0;   // segments still to go in the current list

  line_angle_window_filter #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .last_segment_i  (last_segment_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .out_start_x_o   (out_start_x_o),
    .out_start_y_o   (out_start_y_o),
    .out_end_x_o     (out_end_x_o),
    .out_end_y_o     (out_end_y_o),
    .segment_angle_o (segment_angle_o),
    .keep_o          (keep_o),
    .last_out_o      (last_out_o)
  );

  // Scoreboard sits beside the block and sees the same pins.
  lawf_checker #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .last_segment_i  (last_segment_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .out_start_x_o   (out_start_x_o),
    .out_start_y_o   (out_start_y_o),
    .out_end_x_o     (out_end_x_o),
    .out_end_y_o     (out_end_y_o),
    .segment_angle_o (segment_angle_o),
    .keep_o          (keep_o),
    .last_out_o      (last_out_o),
    .fail_count      (fail_count),
    .pending         (pending),
    .result_count    (result_count),
    .kept_count      (kept_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("testbench: errors");
      $finish;
    end
  end

  // One segment transaction: present it, hold until the edge that takes it.
  // start stays high on return so back-to-back segments need no second assignment.
  task automatic push_segment(int sx, int sy, int ex, int ey, logic last);
    start          <= 1'b1;
    start_x_i      <= COORD_BITS'(sx);
    start_y_i      <= COORD_BITS'(sy);
    end_x_i        <= COORD_BITS'(ex);
    end_y_i        <= COORD_BITS'(ey);
    last_segment_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    segments_sent++;
  endtask

  // Sender goes quiet for a run of cycles, each idle with pct percent odds.
  task automatic sender_idle(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
  endtask

  // Stop sending and let every outstanding result come back.
  // One edge first so the count already holds the last transaction.
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Register writes back to back; the enable stays high across all three.
  // The last one targets an index past the list with junk and must not land.
  task automatic set_window(int target, int tolerance);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TARGET_ANGLE;
    cfg_wdata_i <= ANGLE_BITS'(target);
    @(posedge clk_i);
    cfg_idx_i   <= REG_ANGLE_TOLERANCE;
    cfg_wdata_i <= ANGLE_BITS'(tolerance);
    @(posedge clk_i);
    cfg_idx_i   <= REG_UNUSED;
    cfg_wdata_i <= ANGLE_BITS'($urandom_range(ANGLE_MAX));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Random segment, grouped into lists of 1..8 that end with the last mark.
  // Short segments and axis-aligned ones stress the fold and rounding near 0 and pi.
  task automatic push_random_segment();
    int   sx, sy, ex, ey, kind;
    logic last;
    sx = $urandom_range(COORD_MAX);
    sy = $urandom_range(COORD_MAX);
    ex = $urandom_range(COORD_MAX);
    ey = $urandom_range(COORD_MAX);
    kind = $urandom_range(99);
    if (kind < 15) begin
      ex = clamp_coord(sx + int'($urandom_range(6)) - 3);
      ey = clamp_coord(sy + int'($urandom_range(6)) - 3);
    end else if (kind < 25) begin
      ex = sx;
      ey = sy;
    end else if (kind < 35) begin
      if ($urandom_range(1)) ex = sx;
      else ey = sy;
    end else if (kind < 40) begin
      sx = $urandom_range(1) ? COORD_MAX : 0;
      sy = $urandom_range(1) ? COORD_MAX : 0;
      ex = $urandom_range(1) ? COORD_MAX : 0;
      ey = $urandom_range(1) ? COORD_MAX : 0;
    end
    if (list_left == 0) list_left = $urandom_range(8, 1);
    list_left--;
    last = (list_left == 0);
    push_segment(sx, sy, ex, ey, last);
  endtask

  initial begin
    int target, tolerance, idle_pct;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed segments under the reset window (target 0, tolerance 0).
    push_segment(0, 0, 0, 0, 1'b0);                             // zero length
    push_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    push_segment(COORD_MAX, COORD_MAX, 0, 0, 1'b0);             // full diagonal
    push_segment(0, 0, COORD_MAX, COORD_MAX, 1'b0);
    push_segment(COORD_MAX, 0, 0, COORD_MAX, 1'b0);
    push_segment(0, COORD_MAX, COORD_MAX, 0, 1'b1);
    push_segment(100, 200, 100, 100, 1'b0);                     // pure y step, angle 0
    push_segment(100, 100, 100, 200, 1'b0);                     // reversed, folds to 0
    push_segment(200, 50, 100, 50, 1'b0);                       // pure x step, quarter turn
    push_segment(100, 50, 200, 50, 1'b1);                       // negative x, still quarter
    push_segment(0, COORD_MAX, 1, 0, 1'b0);                     // just under pi
    push_segment(1, COORD_MAX, 0, 0, 1'b0);                     // just above zero
    push_segment(COORD_MAX, 1, 0, 0, 1'b0);                     // just under quarter turn
    push_segment(0, 1, COORD_MAX, 0, 1'b0);                     // just over quarter turn
    push_segment(1, 0, 0, 0, 1'b0);                             // unit steps
    push_segment(0, 1, 0, 0, 1'b0);
    push_segment(0, 0, 1, 0, 1'b0);
    push_segment(0, 0, 0, 1, 1'b1);
    push_segment(2730, 1365, 1365, 2730, 1'b0);                 // alternating bit patterns
    push_segment(1365, 2730, 2730, 1365, 1'b1);
    drain_pipe();

    // Window settings: extremes, wrap on either edge, reset-like, then random.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin target = ANGLE_MAX; tolerance = ANGLE_MAX; end
        1: begin target = 0;         tolerance = ANGLE_MAX; end
        2: begin target = ANGLE_MAX; tolerance = 0;         end
        3: begin target = 0;         tolerance = 1000;      end  // lower edge wraps
        4: begin target = 32500;     tolerance = 1000;      end  // upper edge wraps
        5: begin target = 16384;     tolerance = 16384;     end  // upper edge hits pi
        6: begin target = 16384;     tolerance = 4000;      end  // no wrap
        7: begin target = 0;         tolerance = 0;         end
        default: begin
          target = $urandom_range(ANGLE_MAX);
          tolerance = $urandom_range(ANGLE_MAX >> 2);
        end
      endcase
      // no idling, sender idle 79 of 100, mixed at 22
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 79;
        default: idle_pct = 22;
      endcase
      set_window(target, tolerance);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_idle(idle_pct);
        push_random_segment();
      end
      // hold off until the pipe is empty before touching the registers again
      drain_pipe();
    end

    drain_pipe();
    repeat (SETTLE) @(posedge clk_i);
    $display("summary: %0d segments in %0d window settings, %0d results, %0d kept, %0d dropped",
             segments_sent, PHASES + 1, result_count, kept_count, result_count - kept_count);
    $display("summary: idle mixes 0/79/22 percent, %0d cycles", cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
